FILE: rtl/core/fcqs_pkg.sv
`timescale 1ns / 1ps

package fcqs_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;
  localparam int QUEUE_DEPTH     = 4;

  // Increment applied to the step terms on every move.
  localparam int STEP_INC = 2;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    Q_UPPER_RIGHT = 2'd0,
    Q_UPPER_LEFT  = 2'd1,
    Q_LOWER_LEFT  = 2'd2,
    Q_LOWER_RIGHT = 2'd3
  } quadrant_t;

  // Control part of one queued iteration.
  typedef struct packed {
    logic       fin;
    logic [3:0] mask;
  } job_ctrl_t;

  localparam int JOB_CTRL_BITS = $bits(job_ctrl_t);

endpackage

FILE: rtl/core/filled_circle_quadrant_spans_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_stall    op, center_x, center_y, radius, quadrant_mask
// out       out_valid / out_stall  span_valid, span_row, span_left, span_right, last, done_res
//
// The front takes one item per cycle while the queue is not full and runs one circle iteration
// on it in that cycle. The back emits one beat per cycle while a job waits and the output is
// free: 2 * (enabled quadrants) beats per item, or one beat for a finished circle or an empty
// mask. A four-entry job queue between them lets the front run ahead while the back drains.
// rst is synchronous; it clears the circle state, the queue and the output valid.
// in_stall is high only while the queue is full; out_stall holds the output register.

module filled_circle_quadrant_spans_top #(
  parameter int COORD_BITS  = fcqs_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = fcqs_pkg::RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [RADIUS_BITS-1:0]       radius,
  input  logic [3:0]                   quadrant_mask,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         span_valid,
  output logic signed [COORD_BITS+1:0] span_row,
  output logic signed [COORD_BITS+1:0] span_left,
  output logic signed [COORD_BITS+1:0] span_right,
  output logic                         last,
  output logic                         done_res
);

  localparam int XB    = RADIUS_BITS + 2;
  localparam int CTW   = fcqs_pkg::JOB_CTRL_BITS;
  localparam int JW    = CTW + 2 * COORD_BITS + 2 * XB;
  localparam int DEPTH = fcqs_pkg::QUEUE_DEPTH;
  localparam int LW    = $clog2(DEPTH + 1);

  logic                     push;
  logic                     pop;
  logic                     q_full;
  logic                     q_empty;
  logic [LW-1:0]            q_level;
  fcqs_pkg::job_ctrl_t      wr_ctrl;
  logic [COORD_BITS-1:0]    wr_cx;
  logic [COORD_BITS-1:0]    wr_cy;
  logic signed [XB-1:0]     wr_x;
  logic signed [XB-1:0]     wr_y;
  logic [JW-1:0]            wr_data;
  logic [JW-1:0]            rd_data;
  fcqs_pkg::job_ctrl_t      rd_ctrl;
  logic [COORD_BITS-1:0]    rd_cx;
  logic [COORD_BITS-1:0]    rd_cy;
  logic signed [XB-1:0]     rd_x;
  logic signed [XB-1:0]     rd_y;

  fcqs_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius        (radius),
    .quadrant_mask (quadrant_mask),
    .q_full        (q_full),
    .push          (push),
    .job_ctrl      (wr_ctrl),
    .job_cx        (wr_cx),
    .job_cy        (wr_cy),
    .job_x         (wr_x),
    .job_y         (wr_y)
  );

  assign wr_data = {wr_ctrl, wr_cx, wr_cy, wr_x, wr_y};

  fcqs_queue #(
    .WIDTH (JW),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty),
    .level   (q_level)
  );

  assign rd_ctrl = fcqs_pkg::job_ctrl_t'(rd_data[JW-1 -: CTW]);
  assign rd_cx   = rd_data[2*XB+2*COORD_BITS-1 -: COORD_BITS];
  assign rd_cy   = rd_data[2*XB+COORD_BITS-1 -: COORD_BITS];
  assign rd_x    = rd_data[2*XB-1 -: XB];
  assign rd_y    = rd_data[XB-1:0];

  fcqs_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_ctrl     (rd_ctrl),
    .q_cx       (rd_cx),
    .q_cy       (rd_cy),
    .q_x        (rd_x),
    .q_y        (rd_y),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .span_valid (span_valid),
    .span_row   (span_row),
    .span_left  (span_left),
    .span_right (span_right),
    .last       (last),
    .done_res   (done_res)
  );

  // A finished-circle beat closes its item and carries no span.
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> last && !span_valid)
    else $error("done beat without last or with a span");

  // Every beat without a span is the only beat of its item.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !span_valid |-> last)
    else $error("beat without span is not last");

  // The job queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= LW'(DEPTH))
    else $error("job queue overflow");

  // Nothing is lost on a pop: the back pops only a present job, never into a held output.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty && (!out_valid || !out_stall))
    else $error("pop from empty queue or into a held output");

endmodule

FILE: rtl/core/fcqs_queue.sv
`timescale 1ns / 1ps

module fcqs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fcqs_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 rd_data,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/fcqs_front.sv
`timescale 1ns / 1ps

module fcqs_front #(
  parameter int COORD_BITS  = fcqs_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = fcqs_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [COORD_BITS-1:0]         center_x,
  input  logic [COORD_BITS-1:0]         center_y,
  input  logic [RADIUS_BITS-1:0]        radius,
  input  logic [3:0]                    quadrant_mask,
  input  logic                          q_full,
  output logic                          push,
  output fcqs_pkg::job_ctrl_t           job_ctrl,
  output logic [COORD_BITS-1:0]         job_cx,
  output logic [COORD_BITS-1:0]         job_cy,
  output logic signed [RADIUS_BITS+1:0] job_x,
  output logic signed [RADIUS_BITS+1:0] job_y
);

  localparam int XB = RADIUS_BITS + 2;
  localparam int DB = RADIUS_BITS + 3;
  localparam int EB = RADIUS_BITS + 5;

  logic signed [XB-1:0]    cur_x;
  logic signed [XB-1:0]    cur_y;
  logic signed [DB-1:0]    step_dx;
  logic signed [DB-1:0]    step_dy;
  logic signed [EB-1:0]    error_term;
  logic [COORD_BITS-1:0]   held_center_x;
  logic [COORD_BITS-1:0]   held_center_y;
  logic [RADIUS_BITS-1:0]  held_radius;
  logic [3:0]              held_mask;
  logic                    active;

  logic                    start;
  logic [RADIUS_BITS-1:0]  rad_eff;
  logic [RADIUS_BITS:0]    two_r;
  logic signed [XB-1:0]    ld_x;
  logic signed [XB-1:0]    ld_y;
  logic signed [DB-1:0]    ld_dx;
  logic signed [DB-1:0]    ld_dy;
  logic signed [EB-1:0]    ld_err;
  logic                    finished;
  logic signed [XB-1:0]    y_next;
  logic signed [DB-1:0]    dy_next;
  logic signed [EB-1:0]    err_mid;
  logic signed [XB-1:0]    x_next;
  logic signed [DB-1:0]    dx_next;
  logic signed [EB-1:0]    err_next;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    start   = (op == fcqs_pkg::OP_START);
    rad_eff = start ? radius : held_radius;
    two_r   = {rad_eff, 1'b0};
    // A start item loads fresh state and then runs its first iteration on it.
    ld_x    = start ? XB'(radius) - XB'(1) : cur_x;
    ld_y    = start ? '0 : cur_y;
    ld_dx   = start ? DB'(1) : step_dx;
    ld_dy   = start ? DB'(1) : step_dy;
    ld_err  = start ? EB'(1) - EB'(two_r) : error_term;

    finished = !(start || active) || (ld_x < ld_y);

    y_next  = ld_y;
    dy_next = ld_dy;
    err_mid = ld_err;
    if (ld_err <= 0) begin
      y_next  = ld_y + XB'(1);
      err_mid = ld_err + EB'(ld_dy);
      dy_next = ld_dy + DB'(fcqs_pkg::STEP_INC);
    end

    x_next   = ld_x;
    dx_next  = ld_dx;
    err_next = err_mid;
    if (err_mid > 0) begin
      x_next   = ld_x - XB'(1);
      dx_next  = ld_dx + DB'(fcqs_pkg::STEP_INC);
      err_next = EB'(err_mid + EB'(dx_next) - EB'(two_r));
    end

    job_ctrl.fin  = finished;
    job_ctrl.mask = start ? quadrant_mask : held_mask;
    job_cx        = start ? center_x : held_center_x;
    job_cy        = start ? center_y : held_center_y;
    job_x         = ld_x;
    job_y         = ld_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      step_dx       <= DB'(1);
      step_dy       <= DB'(1);
      error_term    <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      held_mask     <= '0;
      active        <= 1'b0;
    end else if (push) begin
      if (start) begin
        held_center_x <= center_x;
        held_center_y <= center_y;
        held_radius   <= radius;
        held_mask     <= quadrant_mask;
      end
      active <= !finished;
      if (finished) begin
        cur_x      <= ld_x;
        cur_y      <= ld_y;
        step_dx    <= ld_dx;
        step_dy    <= ld_dy;
        error_term <= ld_err;
      end else begin
        cur_x      <= x_next;
        cur_y      <= y_next;
        step_dx    <= dx_next;
        step_dy    <= dy_next;
        error_term <= err_next;
      end
    end
  end

endmodule

FILE: rtl/core/fcqs_back.sv
`timescale 1ns / 1ps

module fcqs_back #(
  parameter int COORD_BITS  = fcqs_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = fcqs_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  fcqs_pkg::job_ctrl_t           q_ctrl,
  input  logic [COORD_BITS-1:0]         q_cx,
  input  logic [COORD_BITS-1:0]         q_cy,
  input  logic signed [RADIUS_BITS+1:0] q_x,
  input  logic signed [RADIUS_BITS+1:0] q_y,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          span_valid,
  output logic signed [COORD_BITS+1:0]  span_row,
  output logic signed [COORD_BITS+1:0]  span_left,
  output logic signed [COORD_BITS+1:0]  span_right,
  output logic                          last,
  output logic                          done_res
);

  localparam int XB = RADIUS_BITS + 2;
  localparam int OB = COORD_BITS + 2;
  localparam int SW = ((OB > XB) ? OB : XB) + 1;

  logic                 busy;
  logic [3:0]           rem;
  logic                 line;

  logic [3:0]           rem_cur;
  logic                 line_cur;
  fcqs_pkg::quadrant_t  quad;
  logic [3:0]           rem_after;
  logic                 has_span;
  logic                 res_last;
  logic                 upper;
  logic                 right;
  logic signed [SW-1:0] cx_w;
  logic signed [SW-1:0] cy_w;
  logic signed [SW-1:0] row_off;
  logic signed [SW-1:0] col_ext;
  logic signed [OB-1:0] row_v;
  logic signed [OB-1:0] left_v;
  logic signed [OB-1:0] right_v;
  logic                 load;

  always_comb begin
    rem_cur  = busy ? rem : q_ctrl.mask;
    line_cur = busy ? line : 1'b0;

    if (rem_cur[0]) begin
      quad = fcqs_pkg::Q_UPPER_RIGHT;
    end else if (rem_cur[1]) begin
      quad = fcqs_pkg::Q_UPPER_LEFT;
    end else if (rem_cur[2]) begin
      quad = fcqs_pkg::Q_LOWER_LEFT;
    end else begin
      quad = fcqs_pkg::Q_LOWER_RIGHT;
    end
    rem_after = rem_cur & ~(4'b0001 << quad);

    has_span = !q_ctrl.fin && (rem_cur != 4'b0000);
    res_last = !has_span || (line_cur && (rem_after == 4'b0000));

    upper = (quad == fcqs_pkg::Q_UPPER_RIGHT) || (quad == fcqs_pkg::Q_UPPER_LEFT);
    right = (quad == fcqs_pkg::Q_UPPER_RIGHT) || (quad == fcqs_pkg::Q_LOWER_RIGHT);

    // The first line of a quadrant is offset by y and reaches x; the second swaps them.
    cx_w    = SW'({1'b0, q_cx});
    cy_w    = SW'({1'b0, q_cy});
    row_off = line_cur ? SW'(q_x) : SW'(q_y);
    col_ext = line_cur ? SW'(q_y) : SW'(q_x);

    row_v   = upper ? OB'(cy_w - row_off) : OB'(cy_w + row_off);
    left_v  = right ? OB'(cx_w) : OB'(cx_w - col_ext);
    right_v = right ? OB'(cx_w + col_ext) : OB'(cx_w);

    load = !q_empty && (!out_valid || !out_stall);
    pop  = load && res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      rem       <= '0;
      line      <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      if (res_last) begin
        busy <= 1'b0;
      end else begin
        busy <= 1'b1;
        line <= !line_cur;
        rem  <= line_cur ? rem_after : rem_cur;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      span_valid <= has_span;
      span_row   <= has_span ? row_v : '0;
      span_left  <= has_span ? left_v : '0;
      span_right <= has_span ? right_v : '0;
      last       <= res_last;
      done_res   <= q_ctrl.fin;
    end
  end

endmodule
